// File: hdl/cdt_gaussian_sampler_defines.svh
// ----------------------------------------------------------------------------
// cdt_gaussian_sampler_defines.svh
// Assertion macros for the CDT Gaussian sampler.
// ----------------------------------------------------------------------------
`ifndef CDT_GAUSSIAN_SAMPLER_DEFINES_SVH
`define CDT_GAUSSIAN_SAMPLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property while out of reset
`define CDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every edge, reset included
`define CDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDT_ASSERT(label, prop, msg)
`define CDT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Widths and register indexes shared by the CDT Gaussian sampler.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int MOD_W   = 63;
  localparam int PROB_W  = 32;
  localparam int RMAG_W  = 31;
  localparam int LEN_W   = 7;
  localparam int MAG_W   = 7;
  localparam int IDX_W   = 6;
  localparam int CFG_A_W = 2;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_MODULUS      = 2'd0,
    CFG_HALF_CENTER  = 2'd1,
    CFG_TABLE_LENGTH = 2'd2
  } cfg_index_t;

  localparam logic [MOD_W-1:0]  MODULUS_RST      = 63'd2;
  localparam logic [PROB_W-1:0] HALF_CENTER_RST  = 32'd0;
  localparam logic [LEN_W-1:0]  TABLE_LENGTH_RST = 7'd64;

endpackage

// File: hdl/cdt_ram.sv
// ----------------------------------------------------------------------------
// cdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/cdt_gaussian_sampler.sv
// ----------------------------------------------------------------------------
// cdt_gaussian_sampler
// Discrete Gaussian sampler by linear search of a cumulative table, with
// one shared subtractor doing the threshold, the table compares and the
// modular negation.
// ----------------------------------------------------------------------------
// A sample word runs through PREP, SEARCH (k table entries read, 1 ..
// active length, none in the centre) and MODQ, which registers the result;
// busy stays high until IDLE, so no new word is taken while a sample is in
// flight, and the receiver cannot stall the strobe. The rate is set by the
// table RAM's single read port, one entry a cycle. A load word is written
// when accepted and leaves busy low. Synchronous active-low reset restores
// the control and config registers; the table RAM is not cleared.
// ----------------------------------------------------------------------------
`include "cdt_gaussian_sampler_defines.svh"

module cdt_gaussian_sampler #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [cdt_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [cdt_pkg::PROB_W-1:0]   in_entry_value,
  input  logic                         in_random_negative,
  input  logic [cdt_pkg::RMAG_W-1:0]   in_random_magnitude,
  input  logic                         in_last_in,
  output logic                         out_valid,
  output logic [cdt_pkg::MAG_W-1:0]    out_magnitude,
  output logic                         out_is_negative,
  output logic [cdt_pkg::MOD_W-1:0]    out_value_mod_q,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cdt_pkg::CFG_A_W-1:0]  cfg_index,
  input  logic [cdt_pkg::MOD_W-1:0]    cfg_data
);

  import cdt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LEN_MAX = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_MAX);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PREP   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_MODQ   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [MOD_W-1:0]   modulus_r;
  logic [PROB_W-1:0]  half_center_r;
  logic [LEN_W-1:0]   table_length_r;
  logic [LEN_W-1:0]   len;

  logic [RMAG_W-1:0]  rmag_r;
  logic               neg_r, neg_nxt;
  logic               last_r, last_nxt;
  logic [PROB_W-1:0]  target_r, target_nxt;
  logic [MAG_W-1:0]   idx_r, idx_nxt, idx_inc;
  logic [MAG_W-1:0]   mag_r, mag_nxt;

  logic [MOD_W-1:0]   sub_a, sub_b;
  logic [MOD_W:0]     sub_d;
  logic               sub_borrow;

  logic               accept, ram_we;
  logic [PROB_W-1:0]  rd_data;

  logic               ov_r, ov_nxt;
  logic [MAG_W-1:0]   omag_r, omag_nxt;
  logic               oneg_r, oneg_nxt;
  logic [MOD_W-1:0]   oval_r, oval_nxt;
  logic               olast_r, olast_nxt;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign ram_we    = accept && !in_kind && (in_entry_index < TABLE_DEPTH);

  assign len = (table_length_r == '0)          ? LEN_W'(1) :
               (table_length_r > LEN_CAP)      ? LEN_CAP   : table_length_r;

  cdt_ram #(
    .WIDTH (PROB_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_entry_value),
    .raddr (AW'(idx_nxt)),
    .rdata (rd_data)
  );

  always_comb begin
    case (state_r)
      S_PREP: begin
        sub_a = MOD_W'(rmag_r);
        sub_b = MOD_W'(half_center_r);
      end
      S_SEARCH: begin
        sub_a = MOD_W'(rd_data);
        sub_b = MOD_W'(target_r);
      end
      S_MODQ: begin
        sub_a = modulus_r;
        sub_b = MOD_W'(mag_r);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_d      = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_d[MOD_W];
  assign idx_inc    = idx_r + MAG_W'(1);

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    last_nxt   = last_r;
    target_nxt = target_r;
    idx_nxt    = '0;
    mag_nxt    = mag_r;
    ov_nxt     = 1'b0;
    omag_nxt   = omag_r;
    oneg_nxt   = oneg_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_kind) begin
          neg_nxt   = in_random_negative;
          last_nxt  = in_last_in;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        target_nxt = sub_d[PROB_W-1:0];
        if (sub_borrow || (sub_d == '0)) begin
          mag_nxt   = '0;
          state_nxt = S_MODQ;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!sub_borrow) begin
          mag_nxt   = idx_inc;
          state_nxt = S_MODQ;
        end else if (idx_inc == len) begin
          mag_nxt   = len;
          state_nxt = S_MODQ;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_MODQ: begin
        ov_nxt    = 1'b1;
        omag_nxt  = mag_r;
        oneg_nxt  = neg_r && (mag_r != '0);
        oval_nxt  = (neg_r && (mag_r != '0)) ? sub_d[MOD_W-1:0] : MOD_W'(mag_r);
        olast_nxt = last_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ov_r           <= 1'b0;
      idx_r          <= '0;
      modulus_r      <= MODULUS_RST;
      half_center_r  <= HALF_CENTER_RST;
      table_length_r <= TABLE_LENGTH_RST;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODULUS:      modulus_r      <= cfg_data;
          CFG_HALF_CENTER:  half_center_r  <= cfg_data[PROB_W-1:0];
          CFG_TABLE_LENGTH: table_length_r <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind) begin
      rmag_r <= in_random_magnitude;
    end
    neg_r    <= neg_nxt;
    last_r   <= last_nxt;
    target_r <= target_nxt;
    mag_r    <= mag_nxt;
    omag_r   <= omag_nxt;
    oneg_r   <= oneg_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_magnitude   = omag_r;
  assign out_is_negative = oneg_r;
  assign out_value_mod_q = oval_r;
  assign out_last        = olast_r;

  `CDT_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `CDT_ASSERT(a_sample_busy, (start && !busy && in_kind) |=> busy, "sample word did not raise busy")
  `CDT_ASSERT(a_load_idle, (start && !busy && !in_kind) |=> !busy, "load word raised busy")
  `CDT_ASSERT(a_idx_bound, (state_r == S_SEARCH) |-> (idx_r < len), "search ran past table length")
  `CDT_ASSERT(a_neg_nonzero, (out_valid && out_is_negative) |-> (out_magnitude != '0),
              "negative flag on zero sample")
  `CDT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !busy), "activity after reset")

endmodule

// File: dv/cdt_gaussian_sampler_tb.sv
// ----------------------------------------------------------------------------
// cdt_gaussian_sampler_tb
// Drives table loads and sample draws through the start/busy port and the
// register write port, predicts every sample from a private copy of the
// table and registers, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module cdt_gaussian_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdt_pkg::*;

  localparam int          TABLE_DEPTH = 64;
  localparam int unsigned RUN_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 70;
  localparam logic [MOD_W-1:0]  MOD_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [PROB_W-1:0] PROB_MAX = 32'h8000_0000;
  localparam logic [RMAG_W-1:0] RMAG_MAX = 31'h7FFF_FFFF;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } word_kind_t;

  typedef struct {
    word_kind_t        kind;
    logic [IDX_W-1:0]  entry_index;
    logic [PROB_W-1:0] entry_value;
    logic              random_negative;
    logic [RMAG_W-1:0] random_magnitude;
    logic              last_in;
  } draw_word_t;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic             is_negative;
    logic [MOD_W-1:0] value_mod_q;
    logic             last;
  } sample_t;

  class sample_tracker;
    logic [MOD_W-1:0]  modulus;
    logic [PROB_W-1:0] half_center;
    logic [LEN_W-1:0]  table_length;
    logic [PROB_W-1:0] cdf [TABLE_DEPTH];
    bit                loaded [TABLE_DEPTH];
    sample_t           pending [$];
    int unsigned       errors;

    function new();
      modulus      = MODULUS_RST;
      half_center  = HALF_CENTER_RST;
      table_length = TABLE_LENGTH_RST;
      foreach (loaded[i]) loaded[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [MOD_W-1:0] data);
      case (idx)
        CFG_MODULUS:      modulus      = data;
        CFG_HALF_CENTER:  half_center  = data[PROB_W-1:0];
        CFG_TABLE_LENGTH: table_length = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_len();
      if (table_length == 0) return 1;
      if (table_length > TABLE_DEPTH) return TABLE_DEPTH;
      return table_length;
    endfunction

    // true when the search for this draw reads written entries only
    function bit reads_defined(logic [RMAG_W-1:0] rmag);
      logic [PROB_W-1:0] tgt;
      int unsigned       i;
      if ({1'b0, rmag} <= half_center) return 1'b1;
      tgt = {1'b0, rmag} - half_center;
      for (i = 0; i < active_len(); i++) begin
        if (!loaded[i]) return 1'b0;
        if (cdf[i] >= tgt) return 1'b1;
      end
      return 1'b1;
    endfunction

    function sample_t predict_sample(draw_word_t w);
      sample_t           s;
      logic [PROB_W-1:0] tgt;
      logic [MAG_W-1:0]  mag;
      int unsigned       n;
      int unsigned       i;
      bit                found;
      mag = '0;
      if ({1'b0, w.random_magnitude} > half_center) begin
        tgt   = {1'b0, w.random_magnitude} - half_center;
        n     = active_len();
        mag   = MAG_W'(n);
        found = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!found && cdf[i] >= tgt) begin
            mag   = MAG_W'(i + 1);
            found = 1'b1;
          end
        end
      end
      s.magnitude   = mag;
      s.is_negative = w.random_negative && (mag != 0);
      s.value_mod_q = s.is_negative ? modulus - MOD_W'(mag) : MOD_W'(mag);
      s.last        = w.last_in;
      return s;
    endfunction

    function void note_input(draw_word_t w);
      if (w.kind == KIND_LOAD) begin
        cdf[w.entry_index]    = w.entry_value;
        loaded[w.entry_index] = 1'b1;
      end else begin
        pending = {pending, predict_sample(w)};
      end
    endfunction

    function void compare_field(string name, logic [MOD_W-1:0] exp_v, logic [MOD_W-1:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(logic [MAG_W-1:0] mag, logic neg, logic [MOD_W-1:0] modq,
                               logic last);
      sample_t exp_s;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample word, expected none, got magnitude %0d",
                 $time, mag);
        return;
      end
      exp_s = pending.pop_front();
      compare_field("magnitude", MOD_W'(exp_s.magnitude), MOD_W'(mag));
      compare_field("is_negative", MOD_W'(exp_s.is_negative), MOD_W'(neg));
      compare_field("value_mod_q", exp_s.value_mod_q, modq);
      compare_field("last", MOD_W'(exp_s.last), MOD_W'(last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n               = 1'b0;
  logic                start               = 1'b0;
  logic                busy;
  logic                in_kind             = 1'b0;
  logic [IDX_W-1:0]    in_entry_index      = '0;
  logic [PROB_W-1:0]   in_entry_value      = '0;
  logic                in_random_negative  = 1'b0;
  logic [RMAG_W-1:0]   in_random_magnitude = '0;
  logic                in_last_in          = 1'b0;
  logic                out_valid;
  logic [MAG_W-1:0]    out_magnitude;
  logic                out_is_negative;
  logic [MOD_W-1:0]    out_value_mod_q;
  logic                out_last;
  logic                cfg_valid           = 1'b0;
  logic                cfg_ready;
  logic [CFG_A_W-1:0]  cfg_index           = CFG_MODULUS;
  logic [MOD_W-1:0]    cfg_data            = '0;
  int unsigned         cycle_count         = 0;

  sample_tracker tracker = new();

  cdt_gaussian_sampler u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_entry_index      (in_entry_index),
    .in_entry_value      (in_entry_value),
    .in_random_negative  (in_random_negative),
    .in_random_magnitude (in_random_magnitude),
    .in_last_in          (in_last_in),
    .out_valid           (out_valid),
    .out_magnitude       (out_magnitude),
    .out_is_negative     (out_is_negative),
    .out_value_mod_q     (out_value_mod_q),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == RUN_LIMIT);
    $display("FAIL cdt_gaussian_sampler");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result(out_magnitude, out_is_negative, out_value_mod_q, out_last);
  end

  function automatic draw_word_t load_word(int unsigned idx, logic [PROB_W-1:0] val);
    draw_word_t w;
    w.kind             = KIND_LOAD;
    w.entry_index      = IDX_W'(idx);
    w.entry_value      = val;
    w.random_negative  = 1'($urandom);
    w.random_magnitude = RMAG_W'($urandom);
    w.last_in          = 1'($urandom);
    return w;
  endfunction

  function automatic draw_word_t sample_word(logic neg, logic [RMAG_W-1:0] rmag, logic last);
    draw_word_t w;
    w.kind             = KIND_SAMPLE;
    w.entry_index      = IDX_W'($urandom);
    w.entry_value      = $urandom_range(0, PROB_MAX);
    w.random_negative  = neg;
    w.random_magnitude = rmag;
    w.last_in          = last;
    return w;
  endfunction

  // aim half the draws at the table steps, where off-by-one errors show
  function automatic logic [RMAG_W-1:0] pick_magnitude();
    longint      t;
    int unsigned j;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RMAG_MAX;
      2, 3, 4: return RMAG_W'($urandom);
      default: begin
        j = $urandom_range(0, tracker.active_len() - 1);
        t = longint'(tracker.cdf[j]) + longint'(tracker.half_center)
            + longint'($urandom_range(0, 2)) - 1;
        if (t < 0) t = 0;
        if (t > longint'(RMAG_MAX)) t = longint'(RMAG_MAX);
        return t[RMAG_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [MOD_W-1:0] pick_modulus();
    logic [MOD_W-1:0] m;
    case ($urandom_range(0, 3))
      0: m = MOD_W'($urandom_range(2, 70));
      1: m = MOD_MAX;
      default: m = MOD_W'({$urandom, $urandom});
    endcase
    if (m < 2) m = 2;
    return m;
  endfunction

  task automatic send_word(draw_word_t w);
    start               <= 1'b1;
    in_kind             <= w.kind;
    in_entry_index      <= w.entry_index;
    in_entry_value      <= w.entry_value;
    in_random_negative  <= w.random_negative;
    in_random_magnitude <= w.random_magnitude;
    in_last_in          <= w.last_in;
    do @(posedge clk); while (busy);
    tracker.note_input(w);
  endtask

  task automatic maybe_idle(int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
  endtask

  // drop start, then hold until every sample is back and the block is quiet
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [MOD_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
  endtask

  task automatic configure(logic [MOD_W-1:0] m, logic [PROB_W-1:0] hc, logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_HALF_CENTER, MOD_W'(hc));
    write_reg(CFG_TABLE_LENGTH, MOD_W'(len));
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cdf(bit ascending, int unsigned idle_pct);
    int unsigned vals [$];
    int unsigned i;
    for (i = 0; i < tracker.active_len(); i++) vals = {vals, $urandom_range(0, PROB_MAX)};
    if (ascending) vals.sort();
    for (i = 0; i < vals.size(); i++) begin
      send_word(load_word(i, vals[i]));
      maybe_idle(idle_pct);
    end
  endtask

  task automatic run_phase(int unsigned n_draws, int unsigned idle_pct);
    logic [RMAG_W-1:0] rmag;
    int unsigned       k;
    for (k = 0; k < n_draws; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(load_word($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, PROB_MAX)));
      end else begin
        rmag = pick_magnitude();
        if (!tracker.reads_defined(rmag)) rmag = '0;
        send_word(sample_word(1'($urandom), rmag, 1'($urandom)));
      end
      maybe_idle(idle_pct);
    end
  endtask

  initial begin
    int unsigned p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // centre sample straight out of reset, sign ignored
    send_word(sample_word(1'b1, '0, 1'b1));
    settle();

    configure(MOD_MAX, '0, 7'd1);
    send_word(load_word(0, '0));
    send_word(sample_word(1'b1, 31'd1, 1'b0));
    send_word(sample_word(1'b0, RMAG_MAX, 1'b1));
    send_word(load_word(0, PROB_MAX));
    send_word(load_word(63, 32'h7FFF_FFFF));
    send_word(load_word(1, '0));
    send_word(sample_word(1'b1, RMAG_MAX, 1'b1));
    send_word(sample_word(1'b0, '0, 1'b0));
    settle();

    configure(63'd2, PROB_MAX, 7'd0);
    send_word(sample_word(1'b1, RMAG_MAX, 1'b1));
    settle();

    configure(63'd2, 32'h7FFF_FFFE, 7'd2);
    send_word(sample_word(1'b1, RMAG_MAX, 1'b0));
    send_word(sample_word(1'b1, 31'h7FFF_FFFE, 1'b1));
    settle();

    configure(63'd2, '0, 7'd64);
    load_cdf(1'b1, 0);
    run_phase(40, 0);
    settle();

    configure(MOD_MAX, PROB_MAX, 7'd64);
    run_phase(20, 86);
    settle();

    configure(pick_modulus(), $urandom_range(0, PROB_MAX), 7'd1);
    load_cdf(1'b1, 10);
    run_phase(30, 10);
    settle();

    configure(pick_modulus(), $urandom_range(0, 32'h2000_0000), 7'd127);
    load_cdf(1'b0, 0);
    run_phase(40, 0);
    settle();

    configure(63'($urandom_range(2, 70)), $urandom_range(0, 32'h2000_0000),
              LEN_W'($urandom_range(1, 64)));
    load_cdf(1'b1, 86);
    run_phase(40, 86);
    settle();

    configure(pick_modulus(), $urandom_range(0, PROB_MAX), 7'd0);
    run_phase(30, 10);
    settle();

    for (p = 0; p < 3; p++) begin
      configure(pick_modulus(), $urandom_range(0, PROB_MAX), LEN_W'($urandom_range(1, 64)));
      load_cdf($urandom_range(0, 3) != 0, 0);
      run_phase(45, (p == 0) ? 0 : (p == 1) ? 86 : 10);
      settle();
    end

    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("PASS cdt_gaussian_sampler");
    end else begin
      $display("FAIL cdt_gaussian_sampler");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/cdt_pkg.sv
hdl/cdt_ram.sv
hdl/cdt_gaussian_sampler.sv
dv/cdt_gaussian_sampler_tb.sv
